@@ src/cic_pkg.sv @@
// ----------------------------------------------------------------------------
// cic_pkg - shared definitions of the system interrupt controller
// Action codes, register offsets, register field masks and the offset decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cic_pkg;

   // Number of CPUs that are built (1 to 4); the lines are always 4 bits wide.
   localparam int NUM_CPUS = 4;
   localparam int MAX_CPUS = 4;
   localparam logic [MAX_CPUS-1:0] CPU_BUILT_MASK = MAX_CPUS'((1 << NUM_CPUS) - 1);

   // Field widths.
   localparam int ACTION_W = 3;
   localparam int OFFSET_W = 12;
   localparam int DATA_W   = 64;
   localparam int IRQ_W    = 6;
   localparam int CPU_W    = 2;
   localparam int MISC_W   = 44;
   localparam int IIC_W    = 25;

   // Packed stream widths.
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 80;

   // Kind of request carried in tuser.
   typedef enum logic [ACTION_W-1:0] {
      ACT_READ  = 3'd0,
      ACT_WRITE = 3'd1,
      ACT_LINE  = 3'd2,
      ACT_TICK  = 3'd3,
      ACT_ALARM = 3'd4
   } action_type;

   // Register offsets.
   localparam logic [OFFSET_W-1:0] OFF_MISC = 12'h080;
   localparam logic [OFFSET_W-1:0] OFF_DIM0 = 12'h200;
   localparam logic [OFFSET_W-1:0] OFF_DIM1 = 12'h240;
   localparam logic [OFFSET_W-1:0] OFF_DIM2 = 12'h600;
   localparam logic [OFFSET_W-1:0] OFF_DIM3 = 12'h640;
   localparam logic [OFFSET_W-1:0] OFF_DIR0 = 12'h280;
   localparam logic [OFFSET_W-1:0] OFF_DIR1 = 12'h2c0;
   localparam logic [OFFSET_W-1:0] OFF_DIR2 = 12'h680;
   localparam logic [OFFSET_W-1:0] OFF_DIR3 = 12'h6c0;
   localparam logic [OFFSET_W-1:0] OFF_DRIR = 12'h300;
   localparam logic [OFFSET_W-1:0] OFF_IIC0 = 12'h380;
   localparam logic [OFFSET_W-1:0] OFF_IIC1 = 12'h3c0;
   localparam logic [OFFSET_W-1:0] OFF_IIC2 = 12'h700;
   localparam logic [OFFSET_W-1:0] OFF_IIC3 = 12'h740;

   // Miscellaneous register fields.
   localparam logic [MISC_W-1:0] MISC_W1C     = 44'h0_0010_000f_f0;
   localparam logic [MISC_W-1:0] MISC_ACL     = 44'h000_0010_0000;
   localparam logic [MISC_W-1:0] MISC_ABT_ABW = 44'h000_00ff_0000;
   localparam logic [MISC_W-1:0] MISC_ABT     = 44'h000_00f0_0000;
   localparam logic [MISC_W-1:0] MISC_ABW     = 44'h000_000f_0000;
   localparam logic [MISC_W-1:0] MISC_IPREQ   = 44'h000_0000_f000;
   localparam logic [MISC_W-1:0] MISC_RWF     = 44'hf00_0000_0000;
   localparam logic [MISC_W-1:0] MISC_ITI_IPI = 44'h000_0000_0ff0;
   localparam logic [MISC_W-1:0] MISC_RESET   = 44'h008_0000_0000;

   // Interval ignore counter fields.
   localparam int IIC_LOAD_W = 24;

   // Register classes that the decoder tells apart.
   typedef enum logic [2:0] {
      REG_MISC,
      REG_DIM,
      REG_DIR,
      REG_DRIR,
      REG_IIC,
      REG_DUMMY,
      REG_NONE
   } reg_kind_type;

   typedef struct packed {
      reg_kind_type      kind;
      logic [CPU_W-1:0]  slot;
   } reg_dec_type;

   // Maps a byte offset to its register class and per-CPU slot.
   function automatic reg_dec_type decode_offset(input logic [OFFSET_W-1:0] off);
      reg_dec_type dec;
      dec.kind = REG_NONE;
      dec.slot = '0;
      unique case (off) inside
         OFF_MISC: dec.kind = REG_MISC;
         OFF_DIM0: begin dec.kind = REG_DIM; dec.slot = 2'd0; end
         OFF_DIM1: begin dec.kind = REG_DIM; dec.slot = 2'd1; end
         OFF_DIM2: begin dec.kind = REG_DIM; dec.slot = 2'd2; end
         OFF_DIM3: begin dec.kind = REG_DIM; dec.slot = 2'd3; end
         OFF_DIR0: begin dec.kind = REG_DIR; dec.slot = 2'd0; end
         OFF_DIR1: begin dec.kind = REG_DIR; dec.slot = 2'd1; end
         OFF_DIR2: begin dec.kind = REG_DIR; dec.slot = 2'd2; end
         OFF_DIR3: begin dec.kind = REG_DIR; dec.slot = 2'd3; end
         OFF_DRIR: dec.kind = REG_DRIR;
         OFF_IIC0: begin dec.kind = REG_IIC; dec.slot = 2'd0; end
         OFF_IIC1: begin dec.kind = REG_IIC; dec.slot = 2'd1; end
         OFF_IIC2: begin dec.kind = REG_IIC; dec.slot = 2'd2; end
         OFF_IIC3: begin dec.kind = REG_IIC; dec.slot = 2'd3; end
         12'h000, 12'h040, 12'h0c0, 12'h100, 12'h140, 12'h180, 12'h1c0,
         12'h340, 12'h400, 12'h440, 12'h480, 12'h4c0, 12'h580, 12'h5c0,
         12'h780, 12'hc00, 12'hc40, 12'hc80, 12'hcc0: dec.kind = REG_DUMMY;
         default: dec.kind = REG_NONE;
      endcase
      return dec;
   endfunction

endpackage

`default_nettype wire

@@ src/chipset_interrupt_controller.sv @@
// ----------------------------------------------------------------------------
// chipset_interrupt_controller - four-CPU system interrupt controller
// Register block with raw requests, per-CPU masks, interval ignore counters
// and the miscellaneous register; drives per-CPU hard, IPI and timer lines.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | Contents
// ---------+-----------+-----------------------------------------------------
// req_     | in        | tuser: action; tdata: offset, write data, irq, level, cpu
// rsp_     | out       | tuser: access_error; tdata: read data and CPU lines
// csr_     | in        | cpu_present_mask write
//
// One request is taken every cycle while rsp_ does not stall; its result passes
// through the input register, then the result register.
// All decode and state update runs in one pass between those two registers.
// A stall on rsp_ holds the result register and backs up through req_tready.
// Reset is synchronous and active high and restores all controller state at once.
// ----------------------------------------------------------------------------
`default_nettype none

module chipset_interrupt_controller (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // req_tdata, from bit 0: reg_offset[11:0], write_data[63:0],
   // irq_number[5:0], irq_level, cpu_sel[1:0], zero fill
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [cic_pkg::REQ_TDATA_W-1:0]        req_tdata,
   // req_tuser: action[2:0]
   input  wire logic [cic_pkg::ACTION_W-1:0]           req_tuser,
   // rsp_tdata, from bit 0: read_data[63:0], hard_irq_lines[3:0],
   // ipi_lines[3:0], timer_lines[3:0], zero fill
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [cic_pkg::RSP_TDATA_W-1:0]             rsp_tdata,
   // rsp_tuser: access_error
   output logic                                        rsp_tuser,
   input  wire logic                                   csr_wr_en,
   input  wire logic [cic_pkg::MAX_CPUS-1:0]           csr_wr_data
);

   localparam int NC = cic_pkg::MAX_CPUS;

   // Input register.
   logic                               in_valid_ff;
   logic [cic_pkg::ACTION_W-1:0]       in_action_ff;
   logic [cic_pkg::OFFSET_W-1:0]       in_offset_ff;
   logic [cic_pkg::DATA_W-1:0]         in_wdata_ff;
   logic [cic_pkg::IRQ_W-1:0]          in_irq_ff;
   logic                               in_level_ff;
   logic [cic_pkg::CPU_W-1:0]          in_cpu_ff;

   // Result register.
   logic                               rsp_valid_ff;
   logic [cic_pkg::DATA_W-1:0]         rsp_rdata_ff;
   logic                               rsp_err_ff;
   logic [NC-1:0]                      rsp_hard_ff;
   logic [NC-1:0]                      rsp_ipi_ff;
   logic [NC-1:0]                      rsp_timer_ff;

   // Controller state and its next values.
   logic [NC-1:0]                      present_ff;
   logic [cic_pkg::MISC_W-1:0]         misc_ff, misc_in;
   logic [cic_pkg::DATA_W-1:0]         raw_ff, raw_in;
   logic [cic_pkg::DATA_W-1:0]         mask_ff [NC];
   logic [cic_pkg::DATA_W-1:0]         mask_in [NC];
   logic [cic_pkg::IIC_W-1:0]          iic_ff [NC];
   logic [cic_pkg::IIC_W-1:0]          iic_in [NC];
   logic [NC-1:0]                      tmr_ff, tmr_in;

   // Result values computed in the pass.
   logic [cic_pkg::DATA_W-1:0]         rdata_in;
   logic                               err_in;
   logic [NC-1:0]                      hard_in, ipi_in, timer_in;

   logic                               advance;
   logic [NC-1:0]                      present;
   cic_pkg::reg_dec_type               dec;
   cic_pkg::action_type                action;

   // The pass runs when the result register is free or being emptied.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign present    = present_ff & cic_pkg::CPU_BUILT_MASK;
   assign dec        = cic_pkg::decode_offset(in_offset_ff);
   assign action     = cic_pkg::action_type'(in_action_ff);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_action_ff <= req_tuser;
         in_offset_ff <= req_tdata[11:0];
         in_wdata_ff  <= req_tdata[75:12];
         in_irq_ff    <= req_tdata[81:76];
         in_level_ff  <= req_tdata[82];
         in_cpu_ff    <= req_tdata[84:83];
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= {NC{1'b1}};
      end else if (csr_wr_en) begin
         present_ff <= csr_wr_data;
      end
   end

   // Decode, state update and line evaluation.
   always_comb begin
      logic [cic_pkg::MISC_W-1:0] wv;
      logic [cic_pkg::MISC_W-1:0] nv;
      logic [cic_pkg::IIC_W-1:0]  cnt;
      misc_in  = misc_ff;
      raw_in   = raw_ff;
      mask_in  = mask_ff;
      iic_in   = iic_ff;
      tmr_in   = tmr_ff;
      rdata_in = '0;
      err_in   = 1'b0;
      wv       = in_wdata_ff[cic_pkg::MISC_W-1:0];
      nv       = misc_ff;
      cnt      = '0;

      unique case (action)
         cic_pkg::ACT_READ: begin
            unique case (dec.kind)
               cic_pkg::REG_MISC:  rdata_in = {20'd0, misc_ff} | {62'd0, in_cpu_ff};
               cic_pkg::REG_DIM:   rdata_in = mask_ff[dec.slot];
               cic_pkg::REG_DIR:   rdata_in = mask_ff[dec.slot] & raw_ff;
               cic_pkg::REG_DRIR:  rdata_in = raw_ff;
               cic_pkg::REG_IIC:   rdata_in = {39'd0, iic_ff[dec.slot]};
               cic_pkg::REG_DUMMY: rdata_in = '0;
               default:            err_in   = 1'b1;
            endcase
         end
         cic_pkg::ACT_WRITE: begin
            unique case (dec.kind)
               cic_pkg::REG_MISC: begin
                  // Clear, set and arbitration fields, then the read-write field.
                  nv = misc_ff & ~(wv & cic_pkg::MISC_W1C);
                  if ((wv & cic_pkg::MISC_ACL) != '0) begin
                     nv = nv & ~cic_pkg::MISC_ABT_ABW;
                  end else begin
                     nv = nv | (wv & cic_pkg::MISC_ABT);
                     if ((nv & cic_pkg::MISC_ABW) == '0) begin
                        nv = nv | (wv & cic_pkg::MISC_ABW);
                     end
                  end
                  nv = nv | ((wv & cic_pkg::MISC_IPREQ) >> 4);
                  nv = (nv & ~cic_pkg::MISC_RWF) | (wv & cic_pkg::MISC_RWF);
                  misc_in = nv;
                  // A change in the ITI or IPI bits drops timer lines whose ITI bit is clear.
                  if (((nv ^ misc_ff) & cic_pkg::MISC_ITI_IPI) != '0) begin
                     for (int i = 0; i < NC; i++) begin
                        if (present[i] && !nv[4+i]) begin
                           tmr_in[i] = 1'b0;
                        end
                     end
                  end
               end
               cic_pkg::REG_DIM: mask_in[dec.slot] = in_wdata_ff;
               cic_pkg::REG_IIC:
                  iic_in[dec.slot] = {1'b0, in_wdata_ff[cic_pkg::IIC_LOAD_W-1:0]};
               cic_pkg::REG_DIR, cic_pkg::REG_DRIR, cic_pkg::REG_DUMMY: ;
               default: err_in = 1'b1;
            endcase
         end
         cic_pkg::ACT_LINE: raw_in[in_irq_ff] = in_level_ff;
         cic_pkg::ACT_TICK: begin
            // On a tick with level high, each present CPU counts down; the overflow bit sticks and raises its timer.
            if (in_level_ff) begin
               for (int i = 0; i < NC; i++) begin
                  if (present[i]) begin
                     cnt = iic_ff[i] - 25'd1;
                     cnt[cic_pkg::IIC_W-1] = cnt[cic_pkg::IIC_W-1] | iic_ff[i][cic_pkg::IIC_W-1];
                     iic_in[i] = cnt;
                     if (cnt[cic_pkg::IIC_W-1]) begin
                        misc_in[4+i] = 1'b1;
                        tmr_in[i]    = 1'b1;
                     end
                  end
               end
            end
         end
         cic_pkg::ACT_ALARM: begin
            if (present[in_cpu_ff]) begin
               misc_in[4+in_cpu_ff] = 1'b1;
               tmr_in[in_cpu_ff]    = 1'b1;
            end
         end
         default: ;
      endcase

      // Lines reflect the state after this request.
      for (int i = 0; i < NC; i++) begin
         hard_in[i]  = present[i] && ((mask_in[i] & raw_in) != '0);
         ipi_in[i]   = present[i] && misc_in[8+i];
         timer_in[i] = present[i] && tmr_in[i];
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         misc_ff <= cic_pkg::MISC_RESET;
         raw_ff  <= '0;
         tmr_ff  <= '0;
         for (int i = 0; i < NC; i++) begin
            mask_ff[i] <= '0;
            iic_ff[i]  <= '0;
         end
      end else if (advance) begin
         misc_ff <= misc_in;
         raw_ff  <= raw_in;
         tmr_ff  <= tmr_in;
         mask_ff <= mask_in;
         iic_ff  <= iic_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_rdata_ff <= rdata_in;
         rsp_err_ff   <= err_in;
         rsp_hard_ff  <= hard_in;
         rsp_ipi_ff   <= ipi_in;
         rsp_timer_ff <= timer_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tdata  = {4'd0, rsp_timer_ff, rsp_ipi_ff, rsp_hard_ff, rsp_rdata_ff};

endmodule

`default_nettype wire

@@ src/cic_checker.sv @@
// ----------------------------------------------------------------------------
// cic_checker - port-level checks of the interrupt controller
// Watches the top-level ports for result framing and handshake behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module cic_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [cic_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input wire logic                               rsp_tuser
);

   // A result that waits keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // No result is presented in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A decode error never carries read data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[63:0] == '0)
      else $error("access error with nonzero read data");

   // With no result waiting, a request can always be taken.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && $past(!rsp_tvalid) && !$past(reset) |-> req_tready)
      else $error("request stalled while output is empty");

endmodule

bind chipset_interrupt_controller cic_checker u_cic_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb - self-checking testbench of the system interrupt controller
// Streams register reads and writes, device line changes, timer ticks and
// alarms into the block, predicts every response with a behavioral copy of
// the register state, and compares each response field by field. The run
// sweeps several present-CPU settings under different stall patterns.
// ----------------------------------------------------------------------------

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cic_pkg::*;

   localparam int PIPE_LATENCY = 2;
   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLDOFF_AT   = 450;
   localparam int HOLDOFF_LEN  = 300;
   localparam int RANDOM_PER_PHASE = 175;
   localparam int NUM_PHASES   = 6;

   // Action codes outside the defined set; the block must ignore them.
   localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

   // Per-CPU register offsets, slot 0 in the lowest entry.
   localparam logic [3:0][OFFSET_W-1:0] DIM_OFFS = {OFF_DIM3, OFF_DIM2, OFF_DIM1, OFF_DIM0};
   localparam logic [3:0][OFFSET_W-1:0] DIR_OFFS = {OFF_DIR3, OFF_DIR2, OFF_DIR1, OFF_DIR0};
   localparam logic [3:0][OFFSET_W-1:0] IIC_OFFS = {OFF_IIC3, OFF_IIC2, OFF_IIC1, OFF_IIC0};

   // Implemented offsets that read as zero and drop writes.
   localparam logic [18:0][OFFSET_W-1:0] DUMMY_OFFS = {
      12'hcc0, 12'hc80, 12'hc40, 12'hc00, 12'h780, 12'h5c0, 12'h580,
      12'h4c0, 12'h480, 12'h440, 12'h400, 12'h340, 12'h1c0, 12'h180,
      12'h140, 12'h100, 12'h0c0, 12'h040, 12'h000};

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [OFFSET_W-1:0] offset;
      logic [DATA_W-1:0]   data;
      logic [IRQ_W-1:0]    irq;
      logic                level;
      logic [CPU_W-1:0]    cpu;
   } cic_request_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              access_error;
      logic [3:0]        hard_lines;
      logic [3:0]        ipi_lines;
      logic [3:0]        timer_lines;
   } cic_response_type;

   // Block ports.
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [ACTION_W-1:0]    req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_wr_en = 1'b0;
   logic [MAX_CPUS-1:0]    csr_wr_data = '0;

   // Shadow copy of the register state.
   logic [3:0]          present_cfg = 4'hf;
   logic [MISC_W-1:0]   misc_q = MISC_RESET;
   logic [DATA_W-1:0]   raw_q = '0;
   logic [DATA_W-1:0]   dim_q [4] = '{default: '0};
   logic [IIC_W-1:0]    iic_q [4] = '{default: '0};
   logic [3:0]          timer_q = '0;

   cic_request_type  req_pending [$];
   cic_response_type expected_responses [$];
   cic_request_type  cur_req = '0;

   int send_idle_pct = 22;
   int recv_idle_pct = 76;
   int error_count = 0;
   int responses_checked = 0;
   int requests_taken = 0;
   int n_reads = 0, n_writes = 0, n_decode_errors = 0;
   int n_hard = 0, n_ipi = 0, n_timer = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   chipset_interrupt_controller uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Sorts an offset into its register class and per-CPU slot.
   function automatic reg_kind_type classify_offset(input logic [OFFSET_W-1:0] off,
                                                    output logic [CPU_W-1:0] slot);
      slot = '0;
      if (off == OFF_MISC) return REG_MISC;
      if (off == OFF_DRIR) return REG_DRIR;
      for (int i = 0; i < 4; i++) begin
         slot = CPU_W'(i);
         if (off == DIM_OFFS[i]) return REG_DIM;
         if (off == DIR_OFFS[i]) return REG_DIR;
         if (off == IIC_OFFS[i]) return REG_IIC;
      end
      slot = '0;
      for (int i = 0; i < 19; i++) begin
         if (off == DUMMY_OFFS[i]) return REG_DUMMY;
      end
      return REG_NONE;
   endfunction

   // Applies one request to the shadow state and returns the response it causes.
   function automatic cic_response_type apply_request(input cic_request_type r);
      cic_response_type o;
      reg_kind_type  kind;
      logic [CPU_W-1:0]  slot;
      logic [3:0]        pres;
      logic [MISC_W-1:0] wr, nxt, old_misc;
      logic [IIC_W-1:0]  cnt;
      o = '0;
      pres = present_cfg & CPU_BUILT_MASK;
      wr = r.data[MISC_W-1:0];
      case (r.action)
         ACT_READ: begin
            n_reads++;
            kind = classify_offset(r.offset, slot);
            case (kind)
               REG_MISC: o.read_data = {{(DATA_W-MISC_W){1'b0}}, misc_q} | DATA_W'(r.cpu);
               REG_DIM:  o.read_data = dim_q[slot];
               REG_DIR:  o.read_data = dim_q[slot] & raw_q;
               REG_DRIR: o.read_data = raw_q;
               REG_IIC:  o.read_data = DATA_W'(iic_q[slot]);
               REG_DUMMY: ;
               default:  o.access_error = 1'b1;
            endcase
         end
         ACT_WRITE: begin
            n_writes++;
            kind = classify_offset(r.offset, slot);
            case (kind)
               REG_MISC: begin
                  old_misc = misc_q;
                  nxt = misc_q & ~(wr & MISC_W1C);
                  // Arbitration clear wins over the arbitration set fields.
                  if ((wr & MISC_ACL) != '0) begin
                     nxt &= ~MISC_ABT_ABW;
                  end else begin
                     nxt |= wr & MISC_ABT;
                     if ((nxt & MISC_ABW) == '0) nxt |= wr & MISC_ABW;
                  end
                  nxt |= (wr & MISC_IPREQ) >> 4;
                  nxt = (nxt & ~MISC_RWF) | (wr & MISC_RWF);
                  misc_q = nxt;
                  // A change in the ITI or IPI bits drops timers whose ITI bit is clear.
                  if (((nxt ^ old_misc) & MISC_ITI_IPI) != '0) begin
                     for (int i = 0; i < 4; i++) begin
                        if (pres[i] && !nxt[4+i]) timer_q[i] = 1'b0;
                     end
                  end
               end
               REG_DIM:  dim_q[slot] = r.data;
               REG_IIC:  iic_q[slot] = IIC_W'(r.data[IIC_LOAD_W-1:0]);
               REG_NONE: o.access_error = 1'b1;
               default: ;
            endcase
         end
         ACT_LINE: raw_q[r.irq] = r.level;
         ACT_TICK: begin
            if (r.level) begin
               for (int i = 0; i < 4; i++) begin
                  if (pres[i]) begin
                     // The overflow bit is sticky until the counter is loaded.
                     cnt = iic_q[i] - 1'b1;
                     cnt[IIC_W-1] = cnt[IIC_W-1] | iic_q[i][IIC_W-1];
                     iic_q[i] = cnt;
                     if (cnt[IIC_W-1]) begin
                        misc_q[4+i] = 1'b1;
                        timer_q[i] = 1'b1;
                     end
                  end
               end
            end
         end
         ACT_ALARM: begin
            if (pres[r.cpu]) begin
               misc_q[4+r.cpu] = 1'b1;
               timer_q[r.cpu] = 1'b1;
            end
         end
         default: ;
      endcase
      for (int i = 0; i < 4; i++) begin
         if (pres[i]) begin
            o.hard_lines[i]  = |(dim_q[i] & raw_q);
            o.ipi_lines[i]   = misc_q[8+i];
            o.timer_lines[i] = timer_q[i];
         end
      end
      if (o.access_error) n_decode_errors++;
      if (o.hard_lines != '0) n_hard++;
      if (o.ipi_lines != '0) n_ipi++;
      if (o.timer_lines != '0) n_timer++;
      return o;
   endfunction

   task automatic queue_request(input logic [ACTION_W-1:0] action,
                                input logic [OFFSET_W-1:0] offset,
                                input logic [DATA_W-1:0] data,
                                input logic [IRQ_W-1:0] irq,
                                input logic level,
                                input logic [CPU_W-1:0] cpu);
      req_pending.push_back('{action, offset, data, irq, level, cpu});
   endtask

   // Builds one random request, mostly aimed at decoded registers.
   function automatic cic_request_type random_request();
      cic_request_type r;
      int sel, kind_sel;
      logic [CPU_W-1:0] slot;
      r.data  = {$urandom, $urandom};
      r.irq   = IRQ_W'($urandom_range(63));
      r.level = 1'($urandom_range(1));
      r.cpu   = CPU_W'($urandom_range(3));
      slot    = CPU_W'($urandom_range(3));
      sel = $urandom_range(99);
      if (sel < 20) r.offset = OFF_MISC;
      else if (sel < 35) r.offset = DIM_OFFS[slot];
      else if (sel < 45) r.offset = DIR_OFFS[slot];
      else if (sel < 50) r.offset = OFF_DRIR;
      else if (sel < 70) r.offset = IIC_OFFS[slot];
      else if (sel < 82) r.offset = DUMMY_OFFS[$urandom_range(18)];
      else r.offset = OFFSET_W'($urandom_range(4095));
      kind_sel = $urandom_range(99);
      if (kind_sel < 25) begin
         r.action = ACT_READ;
      end else if (kind_sel < 50) begin
         r.action = ACT_WRITE;
         // Short counts let the ignore counters run out after a few ticks.
         if (sel >= 50 && sel < 70 && $urandom_range(99) < 60)
            r.data = DATA_W'($urandom_range(12));
         else if (sel < 20) begin
            if ($urandom_range(99) < 40) r.data &= {$urandom, $urandom};
            if ($urandom_range(1) == 0) r.data[20] = 1'b0;
         end
      end else if (kind_sel < 70) begin
         r.action = ACT_LINE;
      end else if (kind_sel < 88) begin
         r.action = ACT_TICK;
         r.level = ($urandom_range(99) < 85);
      end else if (kind_sel < 95) begin
         r.action = ACT_ALARM;
      end else begin
         r.action = ACT_SPARE_FIRST + ACTION_W'($urandom_range(ACT_SPARE_LAST - ACT_SPARE_FIRST));
      end
      return r;
   endfunction

   // Request driver: offers queued requests and predicts each one taken.
   always @(posedge clock) begin
      logic take;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         take = !req_tvalid || req_tready;
         if (req_tvalid && req_tready) begin
            expected_responses.push_back(apply_request(cur_req));
            requests_taken++;
         end
         if (take) begin
            if (req_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_req = req_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {3'b000, cur_req.cpu, cur_req.level, cur_req.irq,
                             cur_req.data, cur_req.offset};
               req_tuser <= cur_req.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks every response and drives the output stalls.
   always @(posedge clock) begin
      cic_response_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.read_data    = rsp_tdata[63:0];
            got.access_error = rsp_tuser;
            got.hard_lines   = rsp_tdata[67:64];
            got.ipi_lines    = rsp_tdata[71:68];
            got.timer_lines  = rsp_tdata[75:72];
            if (expected_responses.size() == 0) begin
               $error("response with no request outstanding: read_data %h", got.read_data);
               error_count++;
            end else begin
               want = expected_responses.pop_front();
               if (got.read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                  error_count++;
               end
               if (got.access_error !== want.access_error) begin
                  $error("access_error: expected %b, got %b",
                         want.access_error, got.access_error);
                  error_count++;
               end
               if (got.hard_lines !== want.hard_lines) begin
                  $error("hard_irq_lines: expected %b, got %b", want.hard_lines, got.hard_lines);
                  error_count++;
               end
               if (got.ipi_lines !== want.ipi_lines) begin
                  $error("ipi_lines: expected %b, got %b", want.ipi_lines, got.ipi_lines);
                  error_count++;
               end
               if (got.timer_lines !== want.timer_lines) begin
                  $error("timer_lines: expected %b, got %b", want.timer_lines, got.timer_lines);
                  error_count++;
               end
            end
            responses_checked++;
            // One long stall so that the block backs up into its input.
            if (responses_checked == HOLDOFF_AT) hold_left = HOLDOFF_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Waits until every request is taken and answered, then for the pipeline.
   task automatic wait_until_idle();
      while (req_pending.size() != 0 || req_tvalid || expected_responses.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_present_mask(input logic [3:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      present_cfg = value;
   endtask

   // Test sequence.
   initial begin
      logic [3:0] mask_plan;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_present_mask(4'hf);

      // Directed part: reset values, field extremes and the odd corners.
      queue_request(ACT_READ,  OFF_MISC, '0, '0, 1'b0, 2'd3);
      queue_request(ACT_READ,  OFF_DRIR, '0, '0, 1'b0, 2'd0);
      queue_request(ACT_LINE,  '0, '0, 6'd0, 1'b1, 2'd0);
      queue_request(ACT_LINE,  '0, '0, 6'd63, 1'b1, 2'd0);
      queue_request(ACT_WRITE, OFF_DIM0, '1, '0, 1'b0, 2'd0);
      queue_request(ACT_WRITE, OFF_DIM3, 64'h8000_0000_0000_0000, '0, 1'b0, 2'd0);
      queue_request(ACT_READ,  OFF_DIR0, '0, '0, 1'b0, 2'd1);
      queue_request(ACT_READ,  OFF_DIR3, '0, '0, 1'b0, 2'd2);
      // A tick with level low changes nothing; the next one wraps every counter.
      queue_request(ACT_TICK,  '0, '0, '0, 1'b0, 2'd0);
      queue_request(ACT_TICK,  '0, '0, '0, 1'b1, 2'd0);
      queue_request(ACT_READ,  OFF_IIC0, '0, '0, 1'b0, 2'd0);
      queue_request(ACT_WRITE, OFF_IIC1, '1, '0, 1'b0, 2'd0);
      queue_request(ACT_ALARM, '0, '0, '0, 1'b0, 2'd2);
      // All ones: arbitration clear, every write-1-to-clear bit, IPI requests.
      queue_request(ACT_WRITE, OFF_MISC, '1, '0, 1'b0, 2'd0);
      queue_request(ACT_WRITE, OFF_MISC, 64'h0000_0000_00f3_0000, '0, 1'b0, 2'd0);
      // The arbitration win field only sets while it is all zero.
      queue_request(ACT_WRITE, OFF_MISC, 64'h0000_0000_000c_0000, '0, 1'b0, 2'd0);
      queue_request(ACT_READ,  OFF_MISC, '0, '0, 1'b0, 2'd1);
      queue_request(ACT_WRITE, OFF_MISC, 64'h0000_0000_0000_0f00, '0, 1'b0, 2'd0);
      // Undecoded offsets, both of them unaligned, and the read-as-zero ones.
      queue_request(ACT_READ,  12'h081, '0, '0, 1'b0, 2'd0);
      queue_request(ACT_WRITE, 12'hfff, '1, '0, 1'b0, 2'd0);
      queue_request(ACT_READ,  12'hcc0, '0, '0, 1'b0, 2'd0);
      queue_request(ACT_WRITE, 12'h000, '1, '0, 1'b0, 2'd0);
      // Read-only registers take writes silently.
      queue_request(ACT_WRITE, OFF_DIR1, '1, '0, 1'b0, 2'd0);
      queue_request(ACT_WRITE, OFF_DRIR, '1, '0, 1'b0, 2'd0);
      queue_request(ACT_SPARE_FIRST, OFF_MISC, '1, 6'd5, 1'b1, 2'd3);
      queue_request(ACT_SPARE_LAST,  OFF_DIM0, '0, 6'd0, 1'b0, 2'd0);
      queue_request(ACT_LINE,  '0, '0, 6'd0, 1'b0, 2'd0);
      wait_until_idle();

      // Random phases over present-CPU settings and stall patterns.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph / 2)
            0: begin send_idle_pct = 22; recv_idle_pct = 76; end
            1: begin send_idle_pct = 76; recv_idle_pct = 22; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case (ph)
            0: mask_plan = 4'hf;
            1: mask_plan = 4'h0;
            2: mask_plan = 4'b1010;
            3: mask_plan = 4'b0101;
            4: mask_plan = 4'($urandom_range(15));
            default: mask_plan = 4'hf;
         endcase
         write_present_mask(mask_plan);
         repeat (RANDOM_PER_PHASE) req_pending.push_back(random_request());
         wait_until_idle();
      end

      $display("Summary: %0d requests (%0d reads, %0d writes, %0d decode errors), %0d responses.",
               requests_taken, n_reads, n_writes, n_decode_errors, responses_checked);
      $display("Active lines in responses: hard %0d, ipi %0d, timer %0d; %0d mask settings.",
               n_hard, n_ipi, n_timer, NUM_PHASES + 1);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ chipset_interrupt_controller.f @@
src/cic_pkg.sv
src/chipset_interrupt_controller.sv
src/cic_checker.sv
tb/tb.sv
